@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, held off while rst_ni is low
`define PFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// condition that must never be seen on a clock edge
`define PFA_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

@@ rtl/pfa_pkg.sv @@
`default_nettype none

package pfa_pkg;

  localparam int FRAME_W   = 20;
  localparam int COUNT_W   = 16;
  localparam int PCOUNT_W  = 13;
  localparam int STATUS_W  = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PCOUNT = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INCR  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTALLOC = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // control from the sequencer to the search walker
  typedef struct packed {
    logic start;
    logic step;
  } walk_ctrl_t;

  // walker status back to the sequencer
  typedef struct packed {
    logic valid;
    logic exhausted;
  } walk_stat_t;

endpackage

`default_nettype wire

@@ rtl/refcounted_page_frame_allocator.sv @@
// Reference-counted page frame allocator.
// Input channel (in_valid_i / in_stall_o) carries cmd_i and frame_i: allocate,
// free, increment or query. Output channel (out_valid_o / out_stall_i) returns
// one item per command: result_frame_o, ref_count_o and status_o.
// base_frame and page_count are set through cfg_we_i / cfg_idx_i / cfg_data_i
// by the user only while the block is idle; the block itself does not enforce it.
// One command is worked on at a time; in_stall_o is high from acceptance until
// its result sits in the output register; no new command is taken before then.
// Free, increment and query pass the range check, count read and update before
// the result is loaded; a frame outside the managed range skips read and update.
// Allocate visits candidates until the free one is found (lower then upper
// neighbour at each distance, out-of-range ones included, one memory read per
// cycle); out of memory is reported once all candidates have been visited.
// After reset every count memory entry is cleared, one entry a cycle, with
// in_stall_o high; configuration writes are taken during that pass.
// A stalled output holds its item; the next command is still accepted and
// finishes up to the point of loading its result, where it waits.
`default_nettype none

module refcounted_page_frame_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [pfa_pkg::FRAME_W-1:0]       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [pfa_pkg::CMD_W-1:0]         cmd_i,
  input  wire logic [pfa_pkg::FRAME_W-1:0]       frame_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [pfa_pkg::FRAME_W-1:0]       result_frame_o,
  output logic      [pfa_pkg::COUNT_W-1:0]       ref_count_o,
  output logic      [pfa_pkg::STATUS_W-1:0]      status_o
);

  `include "assert_macros.svh"

  import pfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int SZ_W  = IDX_W + 1;
  localparam int CMP_W = (FRAME_W + 1 > SZ_W) ? FRAME_W + 1 : SZ_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_SCAN,
    S_OUT
  } state_e;

  state_e                state_q, state_d;
  logic [FRAME_W-1:0]    base_q;
  logic [PCOUNT_W-1:0]   pcount_q;
  logic [IDX_W-1:0]      last_q, last_d;
  logic [IDX_W-1:0]      clr_q, clr_d;
  cmd_e                  cmd_q, cmd_d;
  logic [FRAME_W-1:0]    frame_q, frame_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pend_idx_q, pend_idx_d;
  logic [FRAME_W-1:0]    res_frame_q, res_frame_d;
  logic [COUNT_W-1:0]    res_count_q, res_count_d;
  status_e               res_status_q, res_status_d;
  logic                  out_valid_q, out_valid_d;
  logic [FRAME_W-1:0]    out_frame_q, out_frame_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;
  status_e               out_status_q, out_status_d;

  logic [SZ_W-1:0]       size;
  logic [FRAME_W-1:0]    off;
  logic                  in_range;
  logic                  found;
  logic                  in_acc;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_W-1:0]    ram_rdata;

  walk_ctrl_t            walk_ctrl;
  walk_stat_t            walk_stat;
  logic [IDX_W-1:0]      cand;

  // managed size is page_count clamped to the memory depth
  assign size = (32'(pcount_q) > 32'(MAX_PAGES)) ? SZ_W'(MAX_PAGES) : SZ_W'(pcount_q);

  assign off      = frame_q - base_q;
  assign in_range = (frame_q >= base_q) && (CMP_W'(off) < CMP_W'(size));
  assign found    = (state_q == S_SCAN) && pend_q && (ram_rdata == '0);
  assign in_acc   = in_valid_i && !in_stall_o;

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_frame_o = out_frame_q;
  assign ref_count_o    = out_count_q;
  assign status_o       = out_status_q;

  pfa_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(MAX_PAGES)
  ) u_counts (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pfa_walk #(
    .MAX_PAGES(MAX_PAGES)
  ) u_walk (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(walk_ctrl),
    .last_i(last_q),
    .size_i(size),
    .cand_o(cand),
    .stat_o(walk_stat)
  );

  always_comb begin
    state_d      = state_q;
    last_d       = last_q;
    clr_d        = clr_q;
    cmd_d        = cmd_q;
    frame_d      = frame_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    res_frame_d  = res_frame_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    out_frame_d  = out_frame_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '0;
    ram_raddr    = idx_q;
    walk_ctrl    = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == IDX_W'(MAX_PAGES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = cmd_e'(cmd_i);
          frame_d = frame_i;
          if (cmd_e'(cmd_i) == CMD_ALLOC) begin
            walk_ctrl.start = 1'b1;
            pend_d          = 1'b0;
            state_d         = S_SCAN;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (in_range) begin
          idx_d     = IDX_W'(off);
          ram_raddr = IDX_W'(off);
          state_d   = S_EXEC;
        end else begin
          res_frame_d  = frame_q;
          res_count_d  = '0;
          res_status_d = ST_RANGE;
          state_d      = S_OUT;
        end
      end
      S_EXEC: begin
        res_frame_d = frame_q;
        ram_waddr   = idx_q;
        state_d     = S_OUT;
        priority if (cmd_q == CMD_QUERY) begin
          res_count_d  = ram_rdata;
          res_status_d = ST_OK;
        end else if (ram_rdata == '0) begin
          res_count_d  = '0;
          res_status_d = ST_NOTALLOC;
        end else if (cmd_q == CMD_FREE) begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata - COUNT_W'(1);
          last_d       = idx_q;
          res_count_d  = ram_rdata - COUNT_W'(1);
          res_status_d = ST_OK;
        end else if (ram_rdata == COUNT_MAX) begin
          res_count_d  = COUNT_MAX;
          res_status_d = ST_OVERFLOW;
        end else begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata + COUNT_W'(1);
          last_d       = idx_q;
          res_count_d  = ram_rdata + COUNT_W'(1);
          res_status_d = ST_OK;
        end
      end
      S_SCAN: begin
        // read issued last cycle is checked while the next candidate is read
        priority if (found) begin
          ram_we       = 1'b1;
          ram_waddr    = pend_idx_q;
          ram_wdata    = COUNT_W'(1);
          last_d       = pend_idx_q;
          pend_d       = 1'b0;
          res_frame_d  = base_q + FRAME_W'(pend_idx_q);
          res_count_d  = COUNT_W'(1);
          res_status_d = ST_OK;
          state_d      = S_OUT;
        end else if (walk_stat.exhausted) begin
          pend_d       = 1'b0;
          res_frame_d  = '0;
          res_count_d  = '0;
          res_status_d = ST_NOMEM;
          state_d      = S_OUT;
        end else begin
          walk_ctrl.step = 1'b1;
          ram_raddr      = cand;
          pend_d         = walk_stat.valid;
          pend_idx_d     = cand;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_frame_d  = res_frame_q;
          out_count_d  = res_count_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      base_q       <= '0;
      pcount_q     <= '0;
      last_q       <= '0;
      clr_q        <= '0;
      cmd_q        <= CMD_ALLOC;
      frame_q      <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      res_frame_q  <= '0;
      res_count_q  <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_frame_q  <= '0;
      out_count_q  <= '0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      last_q       <= last_d;
      clr_q        <= clr_d;
      cmd_q        <= cmd_d;
      frame_q      <= frame_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      pend_idx_q   <= pend_idx_d;
      res_frame_q  <= res_frame_d;
      res_count_q  <= res_count_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_frame_q  <= out_frame_d;
      out_count_q  <= out_count_d;
      out_status_q <= out_status_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BASE:   base_q   <= cfg_data_i;
          REG_PCOUNT: pcount_q <= cfg_data_i[PCOUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // count memory is only written by the clear pass, a found slot or an update
  `PFA_ASSERT(a_we_source, ram_we |-> (state_q == S_CLEAR || state_q == S_SCAN || state_q == S_EXEC))
  // a pending search read always lies inside the managed range
  `PFA_ASSERT(a_pend_in_range, (state_q == S_SCAN && pend_q) |-> (SZ_W'(pend_idx_q) < size))
  // allocation moves the last index to the slot it took
  `PFA_ASSERT(a_found_last, found |=> (last_q == $past(pend_idx_q)))
  // out of memory never reports a count
  `PFA_NEVER(a_nomem_count, state_q == S_OUT && res_status_q == ST_NOMEM && res_count_q != '0)

endmodule

`default_nettype wire

@@ rtl/pfa_ram.sv @@
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/pfa_walk.sv @@
`default_nettype none

// outward search order: lower neighbour, then upper one, one candidate a cycle while stepped
module pfa_walk #(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  pfa_pkg::walk_ctrl_t                 ctrl_i,
  input  wire logic [$clog2(MAX_PAGES)-1:0]   last_i,
  input  wire logic [$clog2(MAX_PAGES):0]     size_i,
  output logic      [$clog2(MAX_PAGES)-1:0]   cand_o,
  output pfa_pkg::walk_stat_t                 stat_o
);

  import pfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int SW    = IDX_W + 3;

  logic signed [SW-1:0] lo_q, lo_d;
  logic signed [SW-1:0] hi_q, hi_d;
  logic                 side_q, side_d;
  logic signed [SW-1:0] cur;
  logic signed [SW-1:0] size_s;

  assign size_s = $signed({2'b00, size_i});
  assign cur    = side_q ? hi_q : lo_q;

  assign cand_o           = cur[IDX_W-1:0];
  assign stat_o.valid     = !cur[SW-1] && (cur < size_s);
  assign stat_o.exhausted = lo_q[SW-1] && !(hi_q < size_s);

  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    side_d = side_q;
    priority if (ctrl_i.start) begin
      lo_d   = $signed({3'b000, last_i}) - SW'(1);
      hi_d   = $signed({3'b000, last_i});
      side_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (side_q) begin
        lo_d   = lo_q - SW'(1);
        hi_d   = hi_q + SW'(1);
        side_d = 1'b0;
      end else begin
        side_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= '0;
      side_q <= 1'b0;
    end else begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      side_q <= side_d;
    end
  end

endmodule

`default_nettype wire
